[sv/image_header_size_sniffer_macros.svh]
`ifndef IMAGE_HEADER_SIZE_SNIFFER_MACROS_SVH
`define IMAGE_HEADER_SIZE_SNIFFER_MACROS_SVH
`ifndef SYNTHESIS
`define IHSS_ASSERT_SAME(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IHSS_ASSERT_LATER(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> ##1 (cons)) \
    else $error("assertion failed");
`else
`define IHSS_ASSERT_SAME(lbl, ck, rstn, ante, cons)
`define IHSS_ASSERT_LATER(lbl, ck, rstn, ante, cons)
`endif
`endif

[sv/ihss_pkg.sv]
`default_nettype none
package ihss_pkg;

  localparam int HDR_LEN = 26;

  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_BMP     = 3'd1;
  localparam logic [2:0] KIND_PNG     = 3'd2;
  localparam logic [2:0] KIND_JPEG    = 3'd3;
  localparam logic [2:0] KIND_GIF     = 3'd4;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_INFF,
    PH_LEN,
    PH_SKIP,
    PH_SOF,
    PH_DONE
  } jph_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] width;
    logic [31:0] height;
  } out_t;

  // one finished file: header snapshot, capped byte count, JPEG walk result
  typedef struct packed {
    logic [HDR_LEN-1:0][7:0] hdr;
    logic [4:0]              nbytes;
    logic                    jfound;
    logic [15:0]             jwidth;
    logic [15:0]             jheight;
  } fsum_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

[sv/ihss_front.sv]
`default_nettype none
module ihss_front
  import ihss_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire in_t        in_data,
  output logic            in_stall,
  input  wire fifo_stat_t q_stat,
  output logic            push,
  output fsum_t           push_data
);

  logic [7:0]            hdr_r [HDR_LEN];
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  jph_t                  ph_r, ph_nxt;
  logic [15:0]           rem_r, rem_nxt;
  logic [2:0]            off_r, off_nxt;
  logic [15:0]           jh_r, jh_nxt;
  logic [15:0]           jw_r, jw_nxt;
  logic                  jf_r, jf_nxt;
  logic                  accept;
  logic                  hdr_we;
  logic [7:0]            b;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && in_data.last;
  assign b        = in_data.data_byte;
  assign hdr_we   = cnt_r < COUNT_BITS'(HDR_LEN);

  // JPEG marker walk on the current byte
  always_comb begin
    logic [15:0] len;
    len     = {rem_r[15:8], b};
    ph_nxt  = ph_r;
    rem_nxt = rem_r;
    off_nxt = off_r;
    jh_nxt  = jh_r;
    jw_nxt  = jw_r;
    jf_nxt  = jf_r;
    if (cnt_r >= COUNT_BITS'(2)) begin
      case (ph_r)
        PH_SEEK: begin
          if (cnt_r == COUNT_BITS'(2) && b == 8'hDA) begin
            ph_nxt = PH_DONE;
          end else if (b == 8'hFF) begin
            ph_nxt = PH_INFF;
          end
        end
        PH_INFF: begin
          if (b == 8'hFF) begin
            ph_nxt = PH_INFF;
          end else if (b inside {[8'hC0:8'hC3]}) begin
            ph_nxt  = PH_SOF;
            off_nxt = 3'd1;
          end else if (b == 8'hDA) begin
            ph_nxt = PH_DONE;
          end else begin
            ph_nxt  = PH_LEN;
            off_nxt = 3'd1;
          end
        end
        PH_LEN: begin
          if (off_r == 3'd1) begin
            rem_nxt = {b, 8'h00};
            off_nxt = 3'd2;
          end else if (len < 16'd2) begin
            ph_nxt = PH_DONE;
          end else if (len == 16'd2) begin
            rem_nxt = '0;
            ph_nxt  = PH_SEEK;
          end else begin
            rem_nxt = len - 16'd2;
            ph_nxt  = PH_SKIP;
          end
        end
        PH_SKIP: begin
          rem_nxt = rem_r - 16'd1;
          if (rem_nxt == 16'd0) begin
            ph_nxt = PH_SEEK;
          end
        end
        PH_SOF: begin
          case (off_r)
            3'd4:    jh_nxt = {b, 8'h00};
            3'd5:    jh_nxt = {jh_r[15:8], b};
            3'd6:    jw_nxt = {b, 8'h00};
            3'd7: begin
              jw_nxt = {jw_r[15:8], b};
              jf_nxt = 1'b1;
              ph_nxt = PH_DONE;
            end
            default: ;
          endcase
          off_nxt = off_r + 3'd1;
        end
        default: ph_nxt = PH_DONE;
      endcase
    end
  end

  assign cnt_nxt = (cnt_r == {COUNT_BITS{1'b1}}) ? cnt_r : cnt_r + COUNT_BITS'(1);

  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      push_data.hdr[i] = (hdr_we && cnt_r[4:0] == 5'(i)) ? b : hdr_r[i];
    end
    push_data.nbytes  = (cnt_r >= COUNT_BITS'(31)) ? 5'd31 : 5'(cnt_nxt);
    push_data.jfound  = jf_nxt;
    push_data.jwidth  = jw_nxt;
    push_data.jheight = jh_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept && hdr_we) begin
      hdr_r[cnt_r[4:0]] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ph_r  <= PH_SEEK;
      rem_r <= '0;
      off_r <= '0;
      jh_r  <= '0;
      jw_r  <= '0;
      jf_r  <= 1'b0;
    end else if (accept) begin
      if (in_data.last) begin
        cnt_r <= '0;
        ph_r  <= PH_SEEK;
        rem_r <= '0;
        off_r <= '0;
        jh_r  <= '0;
        jw_r  <= '0;
        jf_r  <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        ph_r  <= ph_nxt;
        rem_r <= rem_nxt;
        off_r <= off_nxt;
        jh_r  <= jh_nxt;
        jw_r  <= jw_nxt;
        jf_r  <= jf_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[sv/ihss_fifo.sv]
`default_nettype none
module ihss_fifo
  import ihss_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire fsum_t push_data,
  input  wire logic  pop,
  output fsum_t      head,
  output fifo_stat_t stat
);

  fsum_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign stat.empty = cnt_r == 2'd0;
  assign stat.full  = cnt_r == 2'd2;
  assign head       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/ihss_back.sv]
`default_nettype none
module ihss_back
  import ihss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire fsum_t      head,
  input  wire fifo_stat_t q_stat,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_t            out_data
);

  logic  out_valid_r;
  out_t  out_r, res;

  assign pop       = !q_stat.empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [HDR_LEN-1:0][7:0] h;
    logic                    png, ihdr, gif;
    h    = head.hdr;
    png  = h[1] == 8'h50 && h[2] == 8'h4E && h[3] == 8'h47;
    ihdr = h[12] == 8'h49 && h[13] == 8'h48 && h[14] == 8'h44 && h[15] == 8'h52;
    gif  = h[0] == 8'h47 && h[1] == 8'h49 && h[2] == 8'h46 && h[3] == 8'h38 &&
           (h[4] == 8'h37 || h[4] == 8'h39) && h[5] == 8'h61;
    res  = '0;
    if (head.nbytes >= 5'd26 && h[0] == 8'h42 && h[1] == 8'h4D) begin
      res.kind   = KIND_BMP;
      res.width  = {h[21], h[20], h[19], h[18]};
      res.height = {h[25], h[24], h[23], h[22]};
    end else if (head.nbytes >= 5'd24 && ihdr && png) begin
      res.kind   = KIND_PNG;
      res.width  = {h[16], h[17], h[18], h[19]};
      res.height = {h[20], h[21], h[22], h[23]};
    end else if (head.nbytes >= 5'd16 && png) begin
      res.kind   = KIND_PNG;
      res.width  = {h[8], h[9], h[10], h[11]};
      res.height = {h[12], h[13], h[14], h[15]};
    end else if (head.nbytes >= 5'd3 && h[0] == 8'hFF && h[1] == 8'hD8) begin
      res.kind = KIND_JPEG;
      if (head.jfound) begin
        res.width  = {16'h0000, head.jwidth};
        res.height = {16'h0000, head.jheight};
      end
    end else if (head.nbytes >= 5'd10 && gif) begin
      res.kind   = KIND_GIF;
      res.width  = {16'h0000, h[7], h[6]};
      res.height = {16'h0000, h[9], h[8]};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[sv/image_header_size_sniffer.sv]
// A file's result is registered in the summary queue, then in the output register.
// Throughput: one byte per cycle; input stalls only while two finished files
// wait in the 2-entry summary queue behind a stalled output register.
// Reset (rst_n low, synchronous): byte count, JPEG walk, queue pointers and
// output valid clear; stored header bytes are not cleared.
`default_nettype none
`include "image_header_size_sniffer_macros.svh"
module image_header_size_sniffer
  import ihss_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  fifo_stat_t q_stat;
  fsum_t      push_data, head;
  logic       push, pop;

  ihss_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  ihss_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  ihss_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  `IHSS_ASSERT_LATER(a_last_reaches_out, clk, rst_n,
                     push && q_stat.empty && !out_valid, out_valid)
  `IHSS_ASSERT_SAME(a_kind_range, clk, rst_n, out_valid, out_data.kind <= KIND_GIF)
  `IHSS_ASSERT_SAME(a_unknown_zero, clk, rst_n,
                    out_valid && out_data.kind == KIND_UNKNOWN,
                    out_data.width == 32'd0 && out_data.height == 32'd0)

endmodule
`default_nettype wire
